[design/laqs_pkg.sv]
`timescale 1ns / 1ps

package laqs_pkg;

    // Operation codes carried in the op field of an input word
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_LIST   = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_STATUS = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Configuration space: one register, selected by address bit 2
    localparam int         CFG_ADDR_W   = 3;
    localparam logic       CFG_CAPACITY = 1'b0;
    localparam logic [4:0] CAP_RESET    = 5'd16;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [4:0]         position;
        logic               is_full;
        logic               is_empty;
        logic               last;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       emit;
        logic [1:0] emit_status;
        logic       scan_start;
        logic       scan_run;
        logic       finish;
    } laqs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       push_blocked;
        logic       pop_bad;
        logic       scan_done;
        logic       out_free;
    } laqs_stat_t;

endpackage

[design/laqs_ctrl.sv]
`timescale 1ns / 1ps

module laqs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  laqs_pkg::laqs_stat_t stat,
    output laqs_pkg::laqs_cmd_t  cmd
);
    import laqs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DISP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.op) inside
                    OP_LIST, OP_SEARCH: begin
                        if (!stat.empty) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                    end
                    OP_PUSH: begin
                        if (stat.out_free) begin
                            cmd.emit = 1'b1;
                            if (stat.push_blocked) begin
                                cmd.emit_status = ST_OVERFLOW;
                            end else begin
                                cmd.push        = 1'b1;
                                cmd.emit_status = ST_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_POP: begin
                        if (stat.out_free) begin
                            cmd.emit = 1'b1;
                            if (stat.pop_bad) begin
                                cmd.emit_status = ST_EMPTY;
                            end else begin
                                cmd.pop         = 1'b1;
                                cmd.emit_status = ST_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        // status query and unused codes
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_OK;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done && stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/laqs_dp.sv]
`timescale 1ns / 1ps

module laqs_dp #(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  laqs_pkg::in_word_t   s_data,
    input  logic [4:0]           capacity,
    input  laqs_pkg::laqs_cmd_t  cmd,
    output laqs_pkg::laqs_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output laqs_pkg::out_word_t  m_data
);
    import laqs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 5) ? CW : 5;
    localparam int PW = (AW + 1 > 5) ? AW + 1 : 5;

    logic [31:0]        mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;

    in_word_t           item_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      tail_reg, tail_next;

    logic [CW-1:0]      scan_idx_reg;
    logic [AW-1:0]      eval_idx_reg;
    logic               eval_vld_reg;
    logic               pend_vld_reg;
    logic signed [31:0] pend_data_reg;
    logic [4:0]         pend_pos_reg;

    logic               out_vld_reg;
    out_word_t          out_reg, out_next;
    logic               out_load;

    logic [EW-1:0]      eff_cap;
    logic               out_free;
    logic               issue;
    logic               match;
    logic               stall;
    logic               advance;
    logic [PW-1:0]      pos_wide;
    logic               flag_full;
    logic               flag_empty;

    // Effective capacity: zero acts as one, above the built depth acts as the depth
    always_comb begin
        if (capacity == 5'd0) begin
            eff_cap = EW'(1);
        end else if (EW'(capacity) > EW'(DEPTH)) begin
            eff_cap = EW'(DEPTH);
        end else begin
            eff_cap = EW'(capacity);
        end
    end

    assign out_free = !out_vld_reg || m_ready;
    assign issue    = scan_idx_reg < tail_reg;
    assign match    = (item_reg.op == OP_LIST) || (rd_data_reg == item_reg.value);
    assign stall    = eval_vld_reg && match && pend_vld_reg && !out_free;
    assign advance  = cmd.scan_run && !stall;
    assign pos_wide = PW'(eval_idx_reg) + PW'(1);

    // Hold the read address on the slot under evaluation while stalled
    always_comb begin
        if (cmd.scan_run) begin
            rd_addr = advance ? scan_idx_reg[AW-1:0] : eval_idx_reg;
        end else begin
            rd_addr = head_reg;
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.push) begin
            tail_next = tail_reg + CW'(1);
        end else if (cmd.pop) begin
            if (CW'(head_reg) + CW'(1) == tail_reg) begin
                head_next = '0;
                tail_next = '0;
            end else begin
                head_next = head_reg + AW'(1);
            end
        end
    end

    assign flag_full  = EW'(tail_next) >= eff_cap;
    assign flag_empty = tail_next == '0;

    always_comb begin
        out_load          = 1'b0;
        out_next          = out_reg;
        out_next.is_full  = flag_full;
        out_next.is_empty = flag_empty;
        if (cmd.emit) begin
            out_load          = 1'b1;
            out_next.status   = cmd.emit_status;
            out_next.data     = cmd.pop ? rd_data_reg : '0;
            out_next.position = '0;
            out_next.last     = 1'b1;
        end else if (cmd.finish) begin
            out_load = 1'b1;
            out_next.last = 1'b1;
            if (pend_vld_reg) begin
                out_next.status   = ST_OK;
                out_next.data     = pend_data_reg;
                out_next.position = pend_pos_reg;
            end else begin
                out_next.status   = ST_NOTFOUND;
                out_next.data     = '0;
                out_next.position = '0;
            end
        end else if (advance && eval_vld_reg && match && pend_vld_reg) begin
            // a newer match exists, so the held one is not the last
            out_load          = 1'b1;
            out_next.status   = ST_OK;
            out_next.data     = pend_data_reg;
            out_next.position = pend_pos_reg;
            out_next.last     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.push) begin
            mem[tail_reg[AW-1:0]] <= item_reg.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            eval_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.scan_start) begin
                scan_idx_reg <= CW'(head_reg);
                eval_vld_reg <= 1'b0;
                pend_vld_reg <= 1'b0;
            end else if (advance) begin
                eval_vld_reg <= issue;
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (eval_vld_reg && match) begin
                    pend_vld_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                pend_vld_reg <= 1'b0;
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (advance) begin
            eval_idx_reg <= scan_idx_reg[AW-1:0];
            if (eval_vld_reg && match) begin
                pend_data_reg <= rd_data_reg;
                pend_pos_reg  <= pos_wide[4:0];
            end
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign stat.op           = item_reg.op;
    assign stat.empty        = tail_reg == '0;
    assign stat.push_blocked = EW'(tail_reg) >= eff_cap;
    assign stat.pop_bad      = (tail_reg == '0) || (CW'(head_reg) >= tail_reg);
    assign stat.scan_done    = !issue && !eval_vld_reg;
    assign stat.out_free     = out_free;

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

[design/linear_array_queue_with_search_unit.sv]
`timescale 1ns / 1ps

// Array queue with search, one operation per input word.
//
// Input channel s_*: one word carries an op (push, pop, list, search, status)
// and a 32-bit value. Output channel m_*: result words, one per push, pop or
// status op, and one per held slot for list, one per matching slot for
// search; the final word of an op has last set. A list or search of an empty
// queue, and a search without a match, give a single error word.
// Timing: a word is taken in the idle state. Push, pop and status load their
// result into the output register from the dispatch state once it is free.
// List and search run a scan over the slot memory, which reads one slot per
// cycle through its one read port while the scan is not stalled.
// Input words are taken one at a time: s_ready is low from acceptance until
// the last result has entered the output register.
// Stall: a held result waits in the output register while m_ready is low;
// the scan keeps one more match aside and then holds until the word drains.
// Reset (aresetn low, synchronous) empties the queue, clears the valid flags and
// sets capacity to 16. Slot contents are not cleared. The user writes capacity
// at APB offset 0 only while the block is idle; the block does not enforce it.

module linear_array_queue_with_search_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  laqs_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output laqs_pkg::out_word_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [laqs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import laqs_pkg::*;

    logic [4:0]  capacity_reg;
    laqs_cmd_t   cmd;
    laqs_stat_t  stat;
    logic        cfg_wr;

    // Register file: capacity only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == CFG_CAPACITY)) begin
            capacity_reg <= pwdata[4:0];
        end
    end

    // Return zero for offsets past the register list
    assign prdata = (paddr[2] == CFG_CAPACITY) ? {27'd0, capacity_reg} : 32'd0;

    laqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    laqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[design/laqs_checker.sv]
`timescale 1ns / 1ps

module laqs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input laqs_pkg::out_word_t m_data
);
    import laqs_pkg::*;

    // Stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // One input word in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice without finishing");

    // Error results stand alone and carry no position
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.last && (m_data.position == 5'd0))
        else $error("error result not final");

    // Empty queue is never full
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |-> !m_data.is_full)
        else $error("empty and full together");

    // Reset drops the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind linear_array_queue_with_search_unit laqs_checker u_laqs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
